// ===== rtl/core/fvla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvla_pkg
// Shared types and constants for the four-voice noise audio unit.
// ----------------------------------------------------------------------------
package fvla_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // configuration register indexes
    localparam logic CFG_PRESCALE_BASE     = 1'b0;
    localparam logic CFG_CYCLES_PER_SAMPLE = 1'b1;

    localparam logic [10:0] PRESCALE_BASE_RESET     = 11'd16;
    localparam logic [15:0] CYCLES_PER_SAMPLE_RESET = 16'd333;

    // per-voice sub-register offsets
    localparam logic [2:0] SUB_VOLUME   = 3'd0;
    localparam logic [2:0] SUB_TAPS     = 3'd1;
    localparam logic [2:0] SUB_OUTPUT   = 3'd2;
    localparam logic [2:0] SUB_SHIFT_LO = 3'd3;
    localparam logic [2:0] SUB_SHIFT_HI = 3'd4;
    localparam logic [2:0] SUB_RELOAD   = 3'd5;
    localparam logic [2:0] SUB_CONTROL  = 3'd6;
    localparam logic [2:0] SUB_COUNT    = 3'd7;

    // global register addresses
    localparam logic [5:0] ADDR_ATTEN_BASE = 6'b001000; // 0x20..0x23, upper six bits
    localparam logic [7:0] ADDR_PAN_MASK    = 8'h28;
    localparam logic [7:0] ADDR_STEREO_MASK = 8'h30;

    // control byte fields
    localparam logic [2:0] SRC_LINKED    = 3'd7;
    localparam int unsigned CTRL_ENABLE    = 3;
    localparam int unsigned CTRL_INTEGRATE = 5;
    localparam int unsigned CTRL_RELOAD    = 6;

    localparam logic [11:0] SHIFT_RESET = 12'h001;
    localparam logic [7:0]  ATTEN_RESET = 8'hff;

    localparam int unsigned TAP_POS [8] = '{0, 1, 2, 3, 4, 5, 7, 10};

    typedef struct packed {
        logic       do_write;
        logic       do_tick;
        logic [2:0] sub;
        logic [7:0] wdata;
    } fvla_cmd_t;

    // shift register bits picked out by the eight selectable taps
    function automatic logic [7:0] tap_bits(input logic [11:0] sr);
        logic [7:0] t;
        for (int i = 0; i < 8; i++)
        begin
            t[i] = sr[TAP_POS[i]];
        end
        return t;
    endfunction

endpackage

// ===== rtl/core/fvla_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvla_if
// Request and response channels of the noise audio unit.
// ----------------------------------------------------------------------------
interface fvla_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;

    modport source (output valid, req_type, reg_addr, write_data, input ready);
    modport sink   (input valid, req_type, reg_addr, write_data, output ready);
endinterface

interface fvla_rsp_if;
    logic              valid;
    logic              ready;
    logic [7:0]        read_data;
    logic              sample_valid;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, read_data, sample_valid, left_sample, right_sample,
                    input ready);
    modport sink   (input valid, read_data, sample_valid, left_sample, right_sample,
                    output ready);
endinterface

// ===== rtl/core/fvla_voice.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvla_voice
// One voice: register bank, prescaler, down counter, noise shift register
// and direct or saturating integrate output.
// ----------------------------------------------------------------------------
module fvla_voice
    import fvla_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  fvla_cmd_t       cmd,
    input  logic            voice_sel,
    input  logic            atten_sel,
    input  logic [10:0]     prescale_base,
    input  logic            carry_in,
    output logic            carry_out,
    output logic [7:0]      rd_data,
    output logic [7:0]      atten,
    output logic [7:0]      out_next
);

    logic [7:0]  volume_reg,  volume_next;
    logic [7:0]  taps_reg,    taps_next;
    logic [7:0]  output_reg,  output_next;
    logic [11:0] shift_reg,   shift_next;
    logic [7:0]  reload_reg,  reload_next;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  count_reg,   count_next;
    logic [7:0]  atten_reg,   atten_next;
    logic        integ_reg,   integ_next;
    logic        enable_reg,  enable_next;
    logic        done_reg,    done_next;
    logic [16:0] phase_reg,   phase_next;

    logic [2:0]  src;
    logic        linked;
    logic        active;
    logic [16:0] period;
    logic [16:0] phase_inc;
    logic        own_count;
    logic        link_count;
    logic        do_count;
    logic        underflow;
    logic        feedback;
    logic [11:0] shift_step;
    logic signed [9:0] vol_ext;
    logic signed [9:0] step;
    logic signed [9:0] acc_base;
    logic signed [9:0] acc_sum;
    logic [7:0]  clamped;

    assign src       = control_reg[2:0];
    assign linked    = (src == SRC_LINKED);
    assign active    = enable_reg && !done_reg;
    assign period    = {6'd0, prescale_base} << src;
    assign phase_inc = phase_reg + 17'd1;

    assign own_count  = cmd.do_tick && active && !linked && (period != 17'd0)
                        && (phase_inc >= period);
    assign link_count = cmd.do_tick && active && linked && carry_in;
    assign do_count   = own_count || link_count;
    assign underflow  = do_count && (count_reg == 8'd0);
    assign carry_out  = underflow;

    // noise shift register clock and new output level
    assign feedback   = ^(taps_reg & tap_bits(shift_reg));
    assign shift_step = {feedback, shift_reg[11:1]};
    assign vol_ext    = $signed({{2{volume_reg[7]}}, volume_reg});
    assign step       = shift_step[0] ? vol_ext : -vol_ext;
    assign acc_base   = integ_reg ? $signed({{2{output_reg[7]}}, output_reg}) : 10'sd0;
    assign acc_sum    = acc_base + step;

    always_comb
    begin
        if (acc_sum > 10'sd127)
        begin
            clamped = 8'h7f;
        end
        else if (acc_sum < -10'sd128)
        begin
            clamped = 8'h80;
        end
        else
        begin
            clamped = acc_sum[7:0];
        end
    end

    always_comb
    begin
        volume_next  = volume_reg;
        taps_next    = taps_reg;
        output_next  = output_reg;
        shift_next   = shift_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        count_next   = count_reg;
        atten_next   = atten_reg;
        integ_next   = integ_reg;
        enable_next  = enable_reg;
        done_next    = done_reg;
        phase_next   = phase_reg;

        if (cmd.do_tick)
        begin
            // prescaler phase
            if (!active)
            begin
                phase_next = 17'd0;
            end
            else if (linked)
            begin
                // a linked voice that goes done here is zeroed like any done voice
                if (underflow)
                begin
                    phase_next = 17'd0;
                end
            end
            else if (period != 17'd0)
            begin
                phase_next = own_count ? 17'd0 : phase_inc;
            end

            if (do_count)
            begin
                count_next = count_reg - 8'd1;
            end
            if (underflow)
            begin
                done_next   = 1'b1;
                count_next  = reload_reg;
                shift_next  = shift_step;
                output_next = clamped;
            end
        end

        if (cmd.do_write && voice_sel)
        begin
            unique case (cmd.sub)
                SUB_VOLUME:   volume_next = cmd.wdata;
                SUB_TAPS:     taps_next   = cmd.wdata;
                SUB_OUTPUT:   output_next = cmd.wdata;
                SUB_SHIFT_LO: shift_next  = {shift_reg[11:8], cmd.wdata};
                SUB_SHIFT_HI: shift_next  = {cmd.wdata[3:0], shift_reg[7:0]};
                SUB_RELOAD:   reload_next = cmd.wdata;
                SUB_CONTROL:
                begin
                    control_next = cmd.wdata;
                    enable_next  = cmd.wdata[CTRL_ENABLE];
                    integ_next   = cmd.wdata[CTRL_INTEGRATE];
                    if (cmd.wdata[CTRL_RELOAD])
                    begin
                        done_next  = 1'b0;
                        count_next = reload_reg;
                    end
                end
                SUB_COUNT:    count_next  = cmd.wdata;
            endcase
        end

        if (cmd.do_write && atten_sel)
        begin
            atten_next = cmd.wdata;
        end
    end

    always_comb
    begin
        unique case (cmd.sub)
            SUB_VOLUME:   rd_data = volume_reg;
            SUB_TAPS:     rd_data = taps_reg;
            SUB_OUTPUT:   rd_data = output_reg;
            SUB_SHIFT_LO: rd_data = shift_reg[7:0];
            SUB_SHIFT_HI: rd_data = {4'd0, shift_reg[11:8]};
            SUB_RELOAD:   rd_data = reload_reg;
            SUB_CONTROL:  rd_data = control_reg;
            SUB_COUNT:    rd_data = count_reg;
        endcase
    end

    assign atten    = atten_reg;
    assign out_next = output_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg  <= 8'd0;
            taps_reg    <= 8'd0;
            output_reg  <= 8'd0;
            shift_reg   <= SHIFT_RESET;
            reload_reg  <= 8'd0;
            control_reg <= 8'd0;
            count_reg   <= 8'd0;
            atten_reg   <= ATTEN_RESET;
            integ_reg   <= 1'b0;
            enable_reg  <= 1'b0;
            done_reg    <= 1'b0;
            phase_reg   <= 17'd0;
        end
        else
        begin
            volume_reg  <= volume_next;
            taps_reg    <= taps_next;
            output_reg  <= output_next;
            shift_reg   <= shift_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
            count_reg   <= count_next;
            atten_reg   <= atten_next;
            integ_reg   <= integ_next;
            enable_reg  <= enable_next;
            done_reg    <= done_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

// ===== rtl/core/fvla_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvla_mixer
// Stereo mix of the voice outputs with per-side enable, pan attenuation
// and clamping to 16-bit samples.
// ----------------------------------------------------------------------------
module fvla_mixer
    import fvla_pkg::*;
#(
    parameter int unsigned NUM_VOICES = 4
)
(
    input  logic signed [7:0]  vout  [NUM_VOICES],
    input  logic [7:0]         atten [NUM_VOICES],
    input  logic [7:0]         stereo_mask,
    input  logic [7:0]         pan_mask,
    output logic signed [15:0] left,
    output logic signed [15:0] right
);

    // s * nib / 16, truncated toward zero
    function automatic logic signed [7:0] scale_term(input logic signed [7:0] s,
                                                     input logic [3:0] nib);
        logic signed [12:0] p;
        logic signed [12:0] q;
        p = $signed({{5{s[7]}}, s}) * $signed({9'd0, nib});
        if (p < 13'sd0)
        begin
            p = p + 13'sd15;
        end
        q = p >>> 4;
        return q[7:0];
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [10:0] acc);
        logic signed [16:0] wide;
        wide = $signed({acc, 6'd0});
        if (wide > 17'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (wide < -17'sd32768)
        begin
            return 16'sh8000;
        end
        return wide[15:0];
    endfunction

    logic signed [10:0] l_acc;
    logic signed [10:0] r_acc;
    logic signed [7:0]  l_term;
    logic signed [7:0]  r_term;

    always_comb
    begin
        l_acc  = 11'sd0;
        r_acc  = 11'sd0;
        l_term = 8'sd0;
        r_term = 8'sd0;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            l_term = pan_mask[4 + v] ? scale_term(vout[v], atten[v][7:4]) : vout[v];
            r_term = pan_mask[v]     ? scale_term(vout[v], atten[v][3:0]) : vout[v];
            if (!stereo_mask[4 + v])
            begin
                l_acc = l_acc + 11'(l_term);
            end
            if (!stereo_mask[v])
            begin
                r_acc = r_acc + 11'(r_term);
            end
        end
    end

    assign left  = clamp16(l_acc);
    assign right = clamp16(r_acc);

endmodule

// ===== rtl/core/four_voice_lfsr_audio_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_voice_lfsr_audio_unit
// Noise audio voices behind byte registers with a stereo sample mixer.
//
//   channel  dir  words
//   req      in   register read, register write or master tick
//   rsp      out  read byte, sample flag, left and right samples
//   cfg      in   prescale base (index 0), cycles per sample (index 1)
//
// One word is taken every cycle while stage one can move; it then passes stage two and stage three to rsp.
// Stage one registers the request, stage two applies it to every voice in a
// single pass (cascade included) and snapshots the levels, stage three mixes.
// A full stage holds while the next is full and held; an empty stage always takes a word.
// Asynchronous reset loads every state and valid register directly; no clearing pass.
// ----------------------------------------------------------------------------
module four_voice_lfsr_audio_unit
    import fvla_pkg::*;
#(
    parameter int unsigned NUM_VOICES = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    fvla_req_if.sink      req,
    fvla_rsp_if.source    rsp,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    // configuration
    logic [10:0] prescale_base_reg;
    logic [15:0] cycles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_base_reg <= PRESCALE_BASE_RESET;
            cycles_reg        <= CYCLES_PER_SAMPLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESCALE_BASE:     prescale_base_reg <= cfg_data[10:0];
                CFG_CYCLES_PER_SAMPLE: cycles_reg        <= cfg_data;
            endcase
        end
    end

    // stage handshakes
    logic a_valid_reg;
    logic b_valid_reg;
    logic rsp_valid_reg;
    logic c_ready;
    logic b_ready;
    logic a_ready;
    logic process;

    assign c_ready   = !rsp_valid_reg || rsp.ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign req.ready = a_ready;
    assign process   = a_valid_reg && b_ready;

    // stage one: request word
    logic [1:0] a_type_reg;
    logic [7:0] a_addr_reg;
    logic [7:0] a_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_type_reg <= req.req_type;
            a_addr_reg <= req.reg_addr;
            a_data_reg <= req.write_data;
        end
    end

    // stage two: voice update
    logic      is_read;
    logic      is_write;
    logic      is_tick;
    fvla_cmd_t cmd;

    assign is_read  = process && (a_type_reg == REQ_READ);
    assign is_write = process && (a_type_reg == REQ_WRITE);
    assign is_tick  = process && (a_type_reg == REQ_TICK);

    assign cmd.do_write = is_write;
    assign cmd.do_tick  = is_tick;
    assign cmd.sub      = a_addr_reg[2:0];
    assign cmd.wdata    = a_data_reg;

    logic [NUM_VOICES-1:0] voice_sel;
    logic [NUM_VOICES-1:0] atten_sel;
    logic [NUM_VOICES-1:0] carry_out;
    logic [7:0]            voice_rd  [NUM_VOICES];
    logic [7:0]            voice_att [NUM_VOICES];
    logic [7:0]            voice_out [NUM_VOICES];

    genvar gv;
    generate
        for (gv = 0; gv < NUM_VOICES; gv++)
        begin : g_voice
            logic carry_in;

            assign voice_sel[gv] = (a_addr_reg[7:5] == 3'd0) && (a_addr_reg[4:3] == 2'(gv));
            assign atten_sel[gv] = (a_addr_reg[7:2] == ADDR_ATTEN_BASE)
                                   && (a_addr_reg[1:0] == 2'(gv));

            if (gv == 0)
            begin : g_first
                assign carry_in = 1'b0;
            end
            else
            begin : g_chain
                assign carry_in = carry_out[gv - 1];
            end

            fvla_voice u_voice (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .voice_sel     (voice_sel[gv]),
                .atten_sel     (atten_sel[gv]),
                .prescale_base (prescale_base_reg),
                .carry_in      (carry_in),
                .carry_out     (carry_out[gv]),
                .rd_data       (voice_rd[gv]),
                .atten         (voice_att[gv]),
                .out_next      (voice_out[gv])
            );
        end
    endgenerate

    // global registers
    logic [7:0]  pan_mask_reg;
    logic [7:0]  stereo_mask_reg;
    logic [15:0] sample_phase_reg;
    logic [15:0] sample_phase_next;
    logic [16:0] sample_phase_inc;
    logic        emit;

    assign sample_phase_inc = {1'b0, sample_phase_reg} + 17'd1;
    assign emit             = is_tick && (sample_phase_inc >= {1'b0, cycles_reg});

    always_comb
    begin
        sample_phase_next = sample_phase_reg;
        if (is_tick)
        begin
            sample_phase_next = emit ? 16'd0 : sample_phase_inc[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_mask_reg     <= 8'd0;
            stereo_mask_reg  <= 8'd0;
            sample_phase_reg <= 16'd0;
        end
        else
        begin
            sample_phase_reg <= sample_phase_next;
            if (is_write && (a_addr_reg == ADDR_PAN_MASK))
            begin
                pan_mask_reg <= a_data_reg;
            end
            if (is_write && (a_addr_reg == ADDR_STEREO_MASK))
            begin
                stereo_mask_reg <= a_data_reg;
            end
        end
    end

    // read mux
    logic [7:0] rd_mux;

    always_comb
    begin
        rd_mux = 8'd0;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            if (voice_sel[v])
            begin
                rd_mux = voice_rd[v];
            end
            if (atten_sel[v])
            begin
                rd_mux = voice_att[v];
            end
        end
        if (a_addr_reg == ADDR_PAN_MASK)
        begin
            rd_mux = pan_mask_reg;
        end
        if (a_addr_reg == ADDR_STEREO_MASK)
        begin
            rd_mux = stereo_mask_reg;
        end
    end

    // stage two register: level snapshot for the mixer
    logic [7:0]        b_rd_reg;
    logic              b_emit_reg;
    logic signed [7:0] b_out_reg   [NUM_VOICES];
    logic [7:0]        b_atten_reg [NUM_VOICES];
    logic [7:0]        b_pan_reg;
    logic [7:0]        b_stereo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_rd_reg     <= is_read ? rd_mux : 8'd0;
            b_emit_reg   <= emit;
            b_pan_reg    <= pan_mask_reg;
            b_stereo_reg <= stereo_mask_reg;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                b_out_reg[v]   <= $signed(voice_out[v]);
                b_atten_reg[v] <= voice_att[v];
            end
        end
    end

    // stage three: mix and response word
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;

    fvla_mixer #(
        .NUM_VOICES (NUM_VOICES)
    ) u_mixer (
        .vout        (b_out_reg),
        .atten       (b_atten_reg),
        .stereo_mask (b_stereo_reg),
        .pan_mask    (b_pan_reg),
        .left        (mix_left),
        .right       (mix_right)
    );

    logic [7:0]         rsp_rd_reg;
    logic               rsp_emit_reg;
    logic signed [15:0] rsp_left_reg;
    logic signed [15:0] rsp_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            rsp_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            rsp_rd_reg    <= b_rd_reg;
            rsp_emit_reg  <= b_emit_reg;
            rsp_left_reg  <= b_emit_reg ? mix_left : 16'sd0;
            rsp_right_reg <= b_emit_reg ? mix_right : 16'sd0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_data    = rsp_rd_reg;
    assign rsp.sample_valid = rsp_emit_reg;
    assign rsp.left_sample  = rsp_left_reg;
    assign rsp.right_sample = rsp_right_reg;

endmodule

// ===== dv/four_voice_lfsr_audio_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_voice_lfsr_audio_unit_test
// Self-checking bench for the four-voice noise audio unit. Register reads,
// register writes and master ticks go in through the request channel. A
// cycle-free model of the voices, counters, noise shifters and stereo mixer
// predicts every response word, and each one is checked field by field. Both
// channels stall at random, and the prescale and sample-rate settings are
// changed between phases.
// ----------------------------------------------------------------------------
module four_voice_lfsr_audio_unit_test;
    import fvla_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [7:0] ADDR_ATTEN0 = {ADDR_ATTEN_BASE, 2'b00};
    localparam logic [7:0] ADDR_UNMAPPED = 8'h38;
    localparam int unsigned TAP_AT [8] = '{0, 1, 2, 3, 4, 5, 7, 10};

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] addr;
        logic [7:0] data;
    } req_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        sample_valid;
        logic [15:0] left_sample;
        logic [15:0] right_sample;
    } rsp_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        drv_valid = 1'b0;
    req_word_t   held = '0;
    logic        take_rsp = 1'b0;
    bit          steady = 1'b0;
    int          bad_words = 0;
    int          queued = 0;
    int unsigned cycle_count = 0;

    req_word_t req_backlog [$];
    rsp_word_t rsp_in_flight [$];

    // unit model state
    logic [7:0]  volume [4];
    logic [7:0]  tap_mask [4];
    logic [7:0]  level [4];
    logic [11:0] noise [4];
    logic [7:0]  reload_val [4];
    logic [7:0]  control [4];
    logic [7:0]  counter [4];
    logic [7:0]  atten [4];
    bit          integrating [4];
    bit          counting [4];
    bit          finished [4];
    int unsigned prescale_ph [4];
    int unsigned sample_ph;
    logic [7:0]  pan_bits;
    logic [7:0]  mute_bits;
    int unsigned base_cfg;
    int unsigned cps_cfg;

    fvla_req_if req_ch ();
    fvla_rsp_if rsp_ch ();

    assign req_ch.valid      = drv_valid;
    assign req_ch.req_type   = held.kind;
    assign req_ch.reg_addr   = held.addr;
    assign req_ch.write_data = held.data;
    assign rsp_ch.ready      = take_rsp;

    four_voice_lfsr_audio_unit #(.NUM_VOICES(4)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    function automatic logic [7:0] clamp_byte(int x);
        if (x > 127)
        begin
            return 8'h7f;
        end
        if (x < -128)
        begin
            return 8'h80;
        end
        return 8'(x);
    endfunction

    function automatic logic [15:0] clamp_word(int x);
        if (x > 32767)
        begin
            return 16'h7fff;
        end
        if (x < -32768)
        begin
            return 16'h8000;
        end
        return 16'(x);
    endfunction

    task automatic step_noise(int v);
        logic [11:0] sr;
        logic        fb;
        int          amp;
        int          delta;
        sr = noise[v];
        fb = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            fb ^= tap_mask[v][i] & sr[TAP_AT[i]];
        end
        sr = {fb, sr[11:1]};
        noise[v] = sr;
        amp = $signed(volume[v]);
        delta = sr[0] ? amp : -amp;
        // -(-128) stays +128 here, so both modes clamp it correctly
        level[v] = integrating[v] ? clamp_byte($signed(level[v]) + delta) : clamp_byte(delta);
    endtask

    // one count; underflow ripples into linked voices above
    task automatic count_down(int v);
        int t;
        bit go;
        t = v;
        go = 1'b1;
        while (go)
        begin
            go = 1'b0;
            counter[t] = counter[t] - 8'd1;
            if (counter[t] == 8'hff)
            begin
                finished[t] = 1'b1;
                counter[t] = reload_val[t];
                step_noise(t);
                if (t < 3 && counting[t + 1] && !finished[t + 1]
                    && control[t + 1][2:0] == SRC_LINKED)
                begin
                    t++;
                    go = 1'b1;
                end
            end
        end
    endtask

    task automatic tick_voice(int v);
        int unsigned period;
        if (!counting[v] || finished[v])
        begin
            prescale_ph[v] = 0;
            return;
        end
        if (control[v][2:0] == SRC_LINKED)
        begin
            return;
        end
        period = base_cfg << control[v][2:0];
        if (period == 0)
        begin
            return;
        end
        prescale_ph[v] = (prescale_ph[v] + 1) & 32'h1ffff;
        if (prescale_ph[v] >= period)
        begin
            prescale_ph[v] = 0;
            count_down(v);
        end
    endtask

    function automatic logic [7:0] read_back(logic [7:0] a);
        int v;
        v = a[4:3];
        if (a < 8'h20)
        begin
            case (a[2:0])
                SUB_VOLUME:   return volume[v];
                SUB_TAPS:     return tap_mask[v];
                SUB_OUTPUT:   return level[v];
                SUB_SHIFT_LO: return noise[v][7:0];
                SUB_SHIFT_HI: return {4'h0, noise[v][11:8]};
                SUB_RELOAD:   return reload_val[v];
                SUB_CONTROL:  return control[v];
                default:      return counter[v];
            endcase
        end
        if (a[7:2] == ADDR_ATTEN_BASE)
        begin
            return atten[a[1:0]];
        end
        if (a == ADDR_PAN_MASK)
        begin
            return pan_bits;
        end
        if (a == ADDR_STEREO_MASK)
        begin
            return mute_bits;
        end
        return 8'h00;
    endfunction

    task automatic write_reg(logic [7:0] a, logic [7:0] d);
        int v;
        v = a[4:3];
        if (a < 8'h20)
        begin
            case (a[2:0])
                SUB_VOLUME:   volume[v] = d;
                SUB_TAPS:     tap_mask[v] = d;
                SUB_OUTPUT:   level[v] = d;
                SUB_SHIFT_LO: noise[v] = {noise[v][11:8], d};
                SUB_SHIFT_HI: noise[v] = {d[3:0], noise[v][7:0]};
                SUB_RELOAD:   reload_val[v] = d;
                SUB_CONTROL:
                begin
                    control[v] = d;
                    counting[v] = d[CTRL_ENABLE];
                    integrating[v] = d[CTRL_INTEGRATE];
                    if (d[CTRL_RELOAD])
                    begin
                        finished[v] = 1'b0;
                        counter[v] = reload_val[v];
                    end
                end
                default:      counter[v] = d;
            endcase
        end
        else if (a[7:2] == ADDR_ATTEN_BASE)
        begin
            atten[a[1:0]] = d;
        end
        else if (a == ADDR_PAN_MASK)
        begin
            pan_bits = d;
        end
        else if (a == ADDR_STEREO_MASK)
        begin
            mute_bits = d;
        end
    endtask

    // applies one request word to the model and gives the response it causes
    task automatic advance_unit(input req_word_t w, output rsp_word_t r);
        int l;
        int rr;
        int s;
        r = '0;
        case (w.kind)
            REQ_READ:  r.read_data = read_back(w.addr);
            REQ_WRITE: write_reg(w.addr, w.data);
            REQ_TICK:
            begin
                for (int v = 0; v < 4; v++)
                begin
                    tick_voice(v);
                end
                sample_ph++;
                if (sample_ph >= cps_cfg)
                begin
                    sample_ph = 0;
                    l = 0;
                    rr = 0;
                    for (int v = 0; v < 4; v++)
                    begin
                        s = $signed(level[v]);
                        // pan scales by the attenuation nibble, truncating toward zero
                        if (!mute_bits[4 + v])
                        begin
                            l += pan_bits[4 + v] ? (s * int'(atten[v] & 8'hf0)) / 256 : s;
                        end
                        if (!mute_bits[v])
                        begin
                            rr += pan_bits[v] ? (s * int'(atten[v] & 8'h0f)) / 16 : s;
                        end
                    end
                    r.sample_valid = 1'b1;
                    r.left_sample = clamp_word(l * 64);
                    r.right_sample = clamp_word(rr * 64);
                end
                sample_ph &= 32'hffff;
            end
            default: ;
        endcase
    endtask

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 38);
    endfunction

    function automatic logic [7:0] voice_reg(int v, logic [2:0] sub);
        return {3'b000, 2'(v), sub};
    endfunction

    function automatic logic [7:0] control_word(logic [2:0] src, bit en, bit integ, bit rl);
        logic [7:0] c;
        c = 8'h00;
        c[2:0] = src;
        c[CTRL_ENABLE] = en;
        c[CTRL_INTEGRATE] = integ;
        c[CTRL_RELOAD] = rl;
        return c;
    endfunction

    function automatic logic [7:0] any_reg();
        case ($urandom_range(9))
            7:       return ADDR_ATTEN0 + 8'($urandom_range(3));
            8:       return ADDR_PAN_MASK;
            9:       return ADDR_STEREO_MASK;
            default: return 8'($urandom_range(31));
        endcase
    endfunction

    task automatic queue_req(logic [1:0] kind, logic [7:0] addr, logic [7:0] data);
        req_word_t w;
        w.kind = kind;
        w.addr = addr;
        w.data = data;
        req_backlog.push_back(w);
        queued++;
    endtask

    task automatic wait_quiet();
        do
        begin
            @(negedge clk);
        end
        while (req_backlog.size() != 0 || drv_valid || rsp_in_flight.size() != 0);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] value);
        wait_quiet();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRESCALE_BASE)
        begin
            base_cfg = value & 16'h07ff;
        end
        else
        begin
            cps_cfg = value;
        end
        @(negedge clk);
    endtask

    // mostly a voice set up and then run for a while, the rest loose words
    task automatic random_traffic(int count);
        int         start;
        int         v;
        logic [2:0] src;
        logic [7:0] c;
        start = queued;
        while (queued - start < count)
        begin
            if ($urandom_range(99) < 72)
            begin
                v = $urandom_range(3);
                queue_req(REQ_WRITE, voice_reg(v, SUB_VOLUME), 8'($urandom));
                if ($urandom_range(1))
                begin
                    queue_req(REQ_WRITE, voice_reg(v, SUB_TAPS), 8'($urandom));
                end
                if ($urandom_range(99) < 30)
                begin
                    queue_req(REQ_WRITE, voice_reg(v, SUB_SHIFT_LO), 8'($urandom));
                    queue_req(REQ_WRITE, voice_reg(v, SUB_SHIFT_HI), 8'($urandom));
                end
                queue_req(REQ_WRITE, voice_reg(v, SUB_RELOAD),
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
                if ($urandom_range(99) < 20)
                begin
                    queue_req(REQ_WRITE, voice_reg(v, SUB_OUTPUT), 8'($urandom));
                end
                if ($urandom_range(99) < 15)
                begin
                    queue_req(REQ_WRITE, voice_reg(v, SUB_COUNT), 8'($urandom_range(5)));
                end
                case ($urandom_range(3))
                    0, 1:    src = 3'($urandom_range(1));
                    2:       src = SRC_LINKED;
                    default: src = 3'($urandom_range(2, 6));
                endcase
                c = control_word(src, $urandom_range(9) != 0, $urandom_range(1),
                                 $urandom_range(9) != 0);
                // spare control bits carry no function but are read back
                c |= 8'($urandom) & 8'h90;
                queue_req(REQ_WRITE, voice_reg(v, SUB_CONTROL), c);
                if ($urandom_range(99) < 25)
                begin
                    case ($urandom_range(2))
                        0: queue_req(REQ_WRITE, ADDR_ATTEN0 + 8'($urandom_range(3)),
                                     8'($urandom));
                        1: queue_req(REQ_WRITE, ADDR_PAN_MASK, 8'($urandom));
                        default: queue_req(REQ_WRITE, ADDR_STEREO_MASK,
                                           $urandom_range(1) ? 8'h00 : 8'($urandom));
                    endcase
                end
                repeat ($urandom_range(4, 28))
                begin
                    queue_req(REQ_TICK, 8'($urandom), 8'($urandom));
                end
                repeat ($urandom_range(1, 3))
                begin
                    queue_req(REQ_READ, any_reg(), 8'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_req(($urandom_range(99) < 8) ? REQ_UNKNOWN : 2'($urandom_range(2)),
                              ($urandom_range(99) < 40) ? 8'($urandom) : any_reg(),
                              8'($urandom));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : driver_proc
        rsp_word_t due;
        if (rst_n)
        begin
            if (drv_valid && req_ch.ready)
            begin
                advance_unit(held, due);
                rsp_in_flight.push_back(due);
            end
            if (!drv_valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && !idle_now())
                begin
                    held <= req_backlog.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor_proc
        rsp_word_t got;
        rsp_word_t want;
        if (rst_n && rsp_ch.valid && take_rsp)
        begin
            got = {rsp_ch.read_data, rsp_ch.sample_valid, rsp_ch.left_sample,
                   rsp_ch.right_sample};
            if (rsp_in_flight.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                begin
                    $display("unexpected word: rd %h sv %b l %0d r %0d", got.read_data,
                             got.sample_valid, $signed(got.left_sample),
                             $signed(got.right_sample));
                end
            end
            else
            begin
                want = rsp_in_flight.pop_front();
                if (got.read_data !== want.read_data || got.sample_valid !== want.sample_valid
                    || got.left_sample !== want.left_sample
                    || got.right_sample !== want.right_sample)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                    begin
                        $display(
                            "mismatch: exp rd %h sv %b l %0d r %0d, got rd %h sv %b l %0d r %0d",
                            want.read_data, want.sample_valid, $signed(want.left_sample),
                            $signed(want.right_sample), got.read_data, got.sample_valid,
                            $signed(got.left_sample), $signed(got.right_sample));
                    end
                end
            end
        end
        take_rsp <= !idle_now();
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL four_voice_lfsr_audio_unit");
        $finish;
    end

    initial
    begin : stimulus
        for (int v = 0; v < 4; v++)
        begin
            volume[v] = 8'h00;
            tap_mask[v] = 8'h00;
            level[v] = 8'h00;
            noise[v] = 12'h001;
            reload_val[v] = 8'h00;
            control[v] = 8'h00;
            counter[v] = 8'h00;
            atten[v] = 8'hff;
            integrating[v] = 1'b0;
            counting[v] = 1'b0;
            finished[v] = 1'b0;
            prescale_ph[v] = 0;
        end
        sample_ph = 0;
        pan_bits = 8'h00;
        mute_bits = 8'h00;
        base_cfg = 16;
        cps_cfg = 333;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_cfg(CFG_PRESCALE_BASE, 16'd1);
        write_cfg(CFG_CYCLES_PER_SAMPLE, 16'd1);

        // reset values, unmapped space and the unknown request type
        queue_req(REQ_READ, voice_reg(0, SUB_SHIFT_LO), 8'h00);
        queue_req(REQ_READ, ADDR_ATTEN0 + 8'd3, 8'h00);
        queue_req(REQ_READ, 8'hff, 8'hff);
        queue_req(REQ_UNKNOWN, 8'hff, 8'hff);
        queue_req(REQ_WRITE, ADDR_UNMAPPED, 8'h55);
        queue_req(REQ_READ, ADDR_UNMAPPED, 8'h00);
        // voice 0 direct at -128, voice 1 linked and integrating at -128
        queue_req(REQ_WRITE, voice_reg(0, SUB_VOLUME), 8'h80);
        queue_req(REQ_WRITE, voice_reg(0, SUB_TAPS), 8'hff);
        queue_req(REQ_WRITE, voice_reg(0, SUB_RELOAD), 8'h00);
        queue_req(REQ_WRITE, voice_reg(1, SUB_VOLUME), 8'h80);
        queue_req(REQ_WRITE, voice_reg(1, SUB_CONTROL), control_word(SRC_LINKED, 1, 1, 1));
        queue_req(REQ_WRITE, voice_reg(0, SUB_CONTROL), control_word(3'd0, 1, 0, 1));
        queue_req(REQ_WRITE, ADDR_PAN_MASK, 8'hff);
        queue_req(REQ_WRITE, ADDR_ATTEN0, 8'hf1);
        queue_req(REQ_WRITE, ADDR_STEREO_MASK, 8'h02);
        repeat (6)
        begin
            queue_req(REQ_TICK, 8'h00, 8'h00);
        end
        queue_req(REQ_READ, voice_reg(0, SUB_OUTPUT), 8'h00);
        queue_req(REQ_READ, voice_reg(1, SUB_OUTPUT), 8'h00);
        queue_req(REQ_READ, voice_reg(0, SUB_SHIFT_HI), 8'h00);
        queue_req(REQ_READ, voice_reg(0, SUB_COUNT), 8'h00);

        random_traffic(190);

        write_cfg(CFG_PRESCALE_BASE, 16'd3);
        write_cfg(CFG_CYCLES_PER_SAMPLE, 16'd7);
        steady = 1'b1;
        random_traffic(150);
        wait_quiet();
        steady = 1'b0;

        // slowest settings: phases build up without reaching their period
        write_cfg(CFG_PRESCALE_BASE, 16'd1024);
        write_cfg(CFG_CYCLES_PER_SAMPLE, 16'd65535);
        random_traffic(60);

        // shrunk periods leave phases past their limit
        write_cfg(CFG_PRESCALE_BASE, 16'd2);
        write_cfg(CFG_CYCLES_PER_SAMPLE, 16'd2);
        random_traffic(150);

        write_cfg(CFG_PRESCALE_BASE, 16'd1);
        write_cfg(CFG_CYCLES_PER_SAMPLE, 16'd3);
        random_traffic(140);

        wait_quiet();
        repeat (10) @(posedge clk);
        if (bad_words == 0 && rsp_in_flight.size() == 0)
        begin
            $display("PASS four_voice_lfsr_audio_unit");
        end
        else
        begin
            $display("FAIL four_voice_lfsr_audio_unit");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fvla_pkg.sv
rtl/core/fvla_if.sv
rtl/core/fvla_voice.sv
rtl/core/fvla_mixer.sv
rtl/core/four_voice_lfsr_audio_unit.sv
dv/four_voice_lfsr_audio_unit_test.sv
